// File: rtl/mmf_pkg.sv
// Shared types, constants and codes for the masked MAC include/exclude filter.
package mmf_pkg;

   localparam int MAC_W = 48;
   localparam int FUNC_W = 2;
   localparam int STATUS_W = 2;
   localparam int COUNT_W = 5;
   localparam int DEFAULT_TABLE_DEPTH = 16;

   localparam logic [FUNC_W-1:0] FUNC_INSERT = 2'd0;
   localparam logic [FUNC_W-1:0] FUNC_QUERY  = 2'd1;
   localparam logic [FUNC_W-1:0] FUNC_CLEAR  = 2'd2;

   localparam logic LIST_INCLUDE = 1'b0;
   localparam logic LIST_EXCLUDE = 1'b1;

   localparam logic [STATUS_W-1:0] STATUS_ADDED   = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_PRESENT = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_FULL    = 2'd2;

   typedef enum logic {
      ST_IDLE,
      ST_RUN
   } state_type;

   // Search beat that walks down the row of cells, collecting match flags.
   typedef struct packed {
      logic [MAC_W-1:0] addr;
      logic             incl_hit;
      logic             excl_hit;
      logic             incl_dup;
      logic             excl_dup;
   } beat_type;

   // Entry write broadcast to the cells.
   typedef struct packed {
      logic             incl_en;
      logic             excl_en;
      logic [MAC_W-1:0] addr;
      logic [MAC_W-1:0] mask;
   } wr_type;

endpackage

// File: rtl/mmf_cell.sv
// One filter cell: holds one include and one exclude entry and compares a passing beat.
module mmf_cell (
   input  logic              clock,
   input  logic              incl_valid,
   input  logic              excl_valid,
   input  mmf_pkg::wr_type   wr,
   input  mmf_pkg::beat_type prev_beat,
   output mmf_pkg::beat_type next_beat
);
   import mmf_pkg::*;

   logic [MAC_W-1:0] incl_addr_ff;
   logic [MAC_W-1:0] incl_mask_ff;
   logic [MAC_W-1:0] excl_addr_ff;
   logic [MAC_W-1:0] excl_mask_ff;
   beat_type         beat_in;
   beat_type         beat_ff;

   always_comb begin
      beat_in = prev_beat;
      beat_in.incl_hit = prev_beat.incl_hit |
         (incl_valid && ((prev_beat.addr & incl_mask_ff) == (incl_addr_ff & incl_mask_ff)));
      beat_in.excl_hit = prev_beat.excl_hit |
         (excl_valid && ((prev_beat.addr & excl_mask_ff) == (excl_addr_ff & excl_mask_ff)));
      beat_in.incl_dup = prev_beat.incl_dup | (incl_valid && (prev_beat.addr == incl_addr_ff));
      beat_in.excl_dup = prev_beat.excl_dup | (excl_valid && (prev_beat.addr == excl_addr_ff));
   end

   always_ff @(posedge clock) begin
      beat_ff <= beat_in;
      if (wr.incl_en) begin
         incl_addr_ff <= wr.addr;
         incl_mask_ff <= wr.mask;
      end
      if (wr.excl_en) begin
         excl_addr_ff <= wr.addr;
         excl_mask_ff <= wr.mask;
      end
   end

   assign next_beat = beat_ff;

endmodule

// File: rtl/mmf_ctrl.sv
// Sequencer, list counts, configuration register and result register of the filter.
module mmf_ctrl #(
   parameter int TABLE_DEPTH = mmf_pkg::DEFAULT_TABLE_DEPTH,
   localparam int CNT_W = $clog2(TABLE_DEPTH + 1),
   localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   output logic                           busy,
   input  logic [mmf_pkg::FUNC_W-1:0]     func,
   input  logic                           which_list,
   input  logic [mmf_pkg::MAC_W-1:0]      addr_mask,
   input  logic                           csr_we,
   input  logic                           csr_wdata,
   input  mmf_pkg::beat_type              tail_beat,
   output mmf_pkg::wr_type                wr,
   output logic [CNT_W-1:0]               incl_used,
   output logic [CNT_W-1:0]               excl_used,
   output logic                           rsp_valid,
   output logic [mmf_pkg::STATUS_W-1:0]   rsp_status,
   output logic                           rsp_allowed,
   output logic [mmf_pkg::COUNT_W-1:0]    rsp_include_count,
   output logic [mmf_pkg::COUNT_W-1:0]    rsp_exclude_count
);
   import mmf_pkg::*;

   localparam logic [IDX_W-1:0] LAST_POS = IDX_W'(TABLE_DEPTH - 1);
   localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(TABLE_DEPTH);

   state_type             state_ff, state_in;
   logic [IDX_W-1:0]      pos_ff, pos_in;
   logic [FUNC_W-1:0]     func_ff;
   logic                  which_ff;
   logic [MAC_W-1:0]      mask_ff;
   logic                  excl_first_ff;
   logic [CNT_W-1:0]      incl_used_ff, incl_used_in;
   logic [CNT_W-1:0]      excl_used_ff, excl_used_in;
   logic                  rsp_valid_ff;
   logic [STATUS_W-1:0]   status_ff, status_in;
   logic                  allowed_ff, allowed_in;
   logic [COUNT_W-1:0]    incl_count_ff, excl_count_ff;
   logic                  accept;
   logic                  finish;
   logic                  add;
   logic                  dup;
   logic [CNT_W-1:0]      target_used;
   logic                  incl_any, excl_any;
   logic [COUNT_W+CNT_W-1:0] incl_wide, excl_wide;

   always_comb begin
      state_in = state_ff;
      pos_in = pos_ff;
      finish = 1'b0;
      accept = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               accept = 1'b1;
               state_in = ST_RUN;
               pos_in = '0;
            end
         end
         ST_RUN: begin
            if (pos_ff == LAST_POS) begin
               finish = 1'b1;
               state_in = ST_IDLE;
            end else begin
               pos_in = pos_ff + 1'b1;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   assign busy = (state_ff == ST_RUN);

   // Decide the result once the beat has passed every cell.
   always_comb begin
      status_in = STATUS_ADDED;
      allowed_in = 1'b0;
      incl_used_in = incl_used_ff;
      excl_used_in = excl_used_ff;
      add = 1'b0;
      incl_any = (incl_used_ff != '0);
      excl_any = (excl_used_ff != '0);
      dup = (which_ff == LIST_EXCLUDE) ? tail_beat.excl_dup : tail_beat.incl_dup;
      target_used = (which_ff == LIST_EXCLUDE) ? excl_used_ff : incl_used_ff;
      case (func_ff)
         FUNC_INSERT: begin
            if (dup) begin
               status_in = STATUS_PRESENT;
            end else if (target_used >= FULL_CNT) begin
               status_in = STATUS_FULL;
            end else begin
               add = 1'b1;
               if (which_ff == LIST_EXCLUDE) begin
                  excl_used_in = excl_used_ff + 1'b1;
               end else begin
                  incl_used_in = incl_used_ff + 1'b1;
               end
            end
         end
         FUNC_QUERY: begin
            if (incl_any && excl_any) begin
               allowed_in = excl_first_ff ? (tail_beat.incl_hit | ~tail_beat.excl_hit)
                                          : (tail_beat.incl_hit & ~tail_beat.excl_hit);
            end else if (incl_any) begin
               allowed_in = tail_beat.incl_hit;
            end else if (excl_any) begin
               allowed_in = ~tail_beat.excl_hit;
            end else begin
               allowed_in = 1'b1;
            end
         end
         FUNC_CLEAR: begin
            incl_used_in = '0;
            excl_used_in = '0;
         end
         default: ;
      endcase
      incl_wide = {{COUNT_W{1'b0}}, incl_used_in};
      excl_wide = {{COUNT_W{1'b0}}, excl_used_in};
   end

   always_comb begin
      wr.incl_en = finish && add && (which_ff == LIST_INCLUDE);
      wr.excl_en = finish && add && (which_ff == LIST_EXCLUDE);
      wr.addr = tail_beat.addr;
      wr.mask = mask_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         pos_ff <= '0;
         excl_first_ff <= 1'b0;
         incl_used_ff <= '0;
         excl_used_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         pos_ff <= pos_in;
         rsp_valid_ff <= finish;
         if (csr_we) begin
            excl_first_ff <= csr_wdata;
         end
         if (finish) begin
            incl_used_ff <= incl_used_in;
            excl_used_ff <= excl_used_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         func_ff <= func;
         which_ff <= which_list;
         mask_ff <= addr_mask;
      end
      if (finish) begin
         status_ff <= status_in;
         allowed_ff <= allowed_in;
         incl_count_ff <= incl_wide[COUNT_W-1:0];
         excl_count_ff <= excl_wide[COUNT_W-1:0];
      end
   end

   assign incl_used = incl_used_ff;
   assign excl_used = excl_used_ff;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_status = status_ff;
   assign rsp_allowed = allowed_ff;
   assign rsp_include_count = incl_count_ff;
   assign rsp_exclude_count = excl_count_ff;

endmodule

// File: rtl/masked_mac_include_exclude_filter.sv
// Masked MAC include/exclude filter: a row of TABLE_DEPTH cells, one entry of each list per cell.
// An accepted item walks the row one cell per cycle, and busy stays high until it reaches the end.
// rsp_valid pulses for one cycle, registered from the final step of the walk.
// A new item can be taken in that same cycle, but not while busy, so items never overlap.
// Synchronous reset empties both lists and clears the configuration bit; no clearing pass.
// The receiver cannot stall, so results are never held back.
module masked_mac_include_exclude_filter #(
   parameter int TABLE_DEPTH = mmf_pkg::DEFAULT_TABLE_DEPTH
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   output logic                           busy,
   input  logic [mmf_pkg::FUNC_W-1:0]     req_func,
   input  logic                           req_which_list,
   input  logic [mmf_pkg::MAC_W-1:0]      req_mac_addr,
   input  logic [mmf_pkg::MAC_W-1:0]      req_addr_mask,
   input  logic                           csr_we,
   input  logic                           csr_wdata,
   output logic                           rsp_valid,
   output logic [mmf_pkg::STATUS_W-1:0]   rsp_status,
   output logic                           rsp_allowed,
   output logic [mmf_pkg::COUNT_W-1:0]    rsp_include_count,
   output logic [mmf_pkg::COUNT_W-1:0]    rsp_exclude_count
);
   import mmf_pkg::*;

   localparam int CNT_W = $clog2(TABLE_DEPTH + 1);

   beat_type         chain [TABLE_DEPTH+1];
   wr_type           wr;
   logic [CNT_W-1:0] incl_used;
   logic [CNT_W-1:0] excl_used;

   assign chain[0] = '{addr: req_mac_addr, incl_hit: 1'b0, excl_hit: 1'b0,
                       incl_dup: 1'b0, excl_dup: 1'b0};

   mmf_ctrl #(
      .TABLE_DEPTH(TABLE_DEPTH)
   ) u_ctrl (
      .clock             (clock),
      .reset             (reset),
      .start             (start),
      .busy              (busy),
      .func              (req_func),
      .which_list        (req_which_list),
      .addr_mask         (req_addr_mask),
      .csr_we            (csr_we),
      .csr_wdata         (csr_wdata),
      .tail_beat         (chain[TABLE_DEPTH]),
      .wr                (wr),
      .incl_used         (incl_used),
      .excl_used         (excl_used),
      .rsp_valid         (rsp_valid),
      .rsp_status        (rsp_status),
      .rsp_allowed       (rsp_allowed),
      .rsp_include_count (rsp_include_count),
      .rsp_exclude_count (rsp_exclude_count)
   );

   for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
      wr_type cell_wr;
      logic   incl_valid;
      logic   excl_valid;

      // A new entry lands in the cell whose index equals the current fill count.
      always_comb begin
         cell_wr = wr;
         cell_wr.incl_en = wr.incl_en && (incl_used == CNT_W'(i));
         cell_wr.excl_en = wr.excl_en && (excl_used == CNT_W'(i));
         incl_valid = (CNT_W'(i) < incl_used);
         excl_valid = (CNT_W'(i) < excl_used);
      end

      mmf_cell u_cell (
         .clock      (clock),
         .incl_valid (incl_valid),
         .excl_valid (excl_valid),
         .wr         (cell_wr),
         .prev_beat  (chain[i]),
         .next_beat  (chain[i+1])
      );
   end

endmodule

// File: bench/testbench.sv
// Self-checking bench for the masked MAC include/exclude filter: directed and random beats.
module testbench;
   import mmf_pkg::*;

   localparam int DEPTH = DEFAULT_TABLE_DEPTH;
   localparam logic [FUNC_W-1:0] FUNC_UNUSED = 2'd3;
   localparam logic [MAC_W-1:0] MAC_ONES = '1;
   localparam int RANDOM_ITEMS = 1950;
   localparam int PHASES = 6;
   localparam int CYCLE_LIMIT = 600000;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic                allowed;
      logic [COUNT_W-1:0]  incl_count;
      logic [COUNT_W-1:0]  excl_count;
   } filter_verdict_type;

   class mac_filter_scoreboard;
      logic [MAC_W-1:0] entry_addr [2][DEPTH];
      logic [MAC_W-1:0] entry_mask [2][DEPTH];
      int unsigned used [2];
      bit excl_first;
      filter_verdict_type verdict_q [$];
      int error_count = 0;
      int verdict_count = 0;
      int query_count = 0;
      int allowed_count = 0;
      int insert_count = 0;
      int present_count = 0;
      int full_count = 0;
      int clear_count = 0;
      int config_writes = 0;

      function new();
         used[0] = 0;
         used[1] = 0;
         excl_first = 0;
      endfunction

      function int pending();
         return verdict_q.size();
      endfunction

      function bit list_hit(int lst, logic [MAC_W-1:0] mac);
         for (int i = 0; i < used[lst]; i++) begin
            if ((mac & entry_mask[lst][i]) == (entry_addr[lst][i] & entry_mask[lst][i]))
               return 1'b1;
         end
         return 1'b0;
      endfunction

      // The duplicate check ignores the mask and wins over a full list.
      function logic [STATUS_W-1:0] list_insert(int lst, logic [MAC_W-1:0] mac,
                                                logic [MAC_W-1:0] msk);
         for (int i = 0; i < used[lst]; i++) begin
            if (entry_addr[lst][i] == mac)
               return STATUS_PRESENT;
         end
         if (used[lst] >= DEPTH)
            return STATUS_FULL;
         entry_addr[lst][used[lst]] = mac;
         entry_mask[lst][used[lst]] = msk;
         used[lst]++;
         return STATUS_ADDED;
      endfunction

      function void apply_command(logic [FUNC_W-1:0] func, logic which,
                                  logic [MAC_W-1:0] mac, logic [MAC_W-1:0] msk);
         filter_verdict_type v;
         bit inc_hit;
         bit exc_hit;
         bit inc_any;
         bit exc_any;
         bit ok;
         v = '0;
         case (func)
            FUNC_INSERT: begin
               v.status = list_insert(int'(which), mac, msk);
               insert_count++;
               if (v.status == STATUS_PRESENT) present_count++;
               if (v.status == STATUS_FULL) full_count++;
            end
            FUNC_QUERY: begin
               inc_hit = list_hit(int'(LIST_INCLUDE), mac);
               exc_hit = list_hit(int'(LIST_EXCLUDE), mac);
               inc_any = used[LIST_INCLUDE] != 0;
               exc_any = used[LIST_EXCLUDE] != 0;
               if (inc_any && exc_any)
                  ok = excl_first ? (inc_hit || !exc_hit) : (inc_hit && !exc_hit);
               else if (inc_any)
                  ok = inc_hit;
               else if (exc_any)
                  ok = !exc_hit;
               else
                  ok = 1'b1;
               v.allowed = ok;
               query_count++;
               if (ok) allowed_count++;
            end
            FUNC_CLEAR: begin
               used[0] = 0;
               used[1] = 0;
               clear_count++;
            end
            default: begin
            end
         endcase
         v.incl_count = COUNT_W'(used[LIST_INCLUDE]);
         v.excl_count = COUNT_W'(used[LIST_EXCLUDE]);
         verdict_q.push_back(v);
      endfunction

      task report(string msg);
         $display("ERROR [%0t] %s", $time, msg);
         error_count++;
      endtask

      task check_verdict(filter_verdict_type got);
         filter_verdict_type exp;
         if (verdict_q.size() == 0) begin
            report("result beat arrived with nothing outstanding");
            return;
         end
         exp = verdict_q.pop_front();
         verdict_count++;
         if (got.status !== exp.status)
            report($sformatf("beat %0d status %0d, want %0d", verdict_count,
                             got.status, exp.status));
         if (got.allowed !== exp.allowed)
            report($sformatf("beat %0d allowed %0d, want %0d", verdict_count,
                             got.allowed, exp.allowed));
         if (got.incl_count !== exp.incl_count)
            report($sformatf("beat %0d include_count %0d, want %0d", verdict_count,
                             got.incl_count, exp.incl_count));
         if (got.excl_count !== exp.excl_count)
            report($sformatf("beat %0d exclude_count %0d, want %0d", verdict_count,
                             got.excl_count, exp.excl_count));
      endtask

      task flush_leftovers();
         while (verdict_q.size() != 0) begin
            void'(verdict_q.pop_front());
            report("expected result beat never arrived");
         end
      endtask
   endclass

   logic                clock;
   logic                reset;
   logic                start;
   logic                busy;
   logic [FUNC_W-1:0]   req_func;
   logic                req_which_list;
   logic [MAC_W-1:0]    req_mac_addr;
   logic [MAC_W-1:0]    req_addr_mask;
   logic                csr_we;
   logic                csr_wdata;
   logic                rsp_valid;
   logic [STATUS_W-1:0] rsp_status;
   logic                rsp_allowed;
   logic [COUNT_W-1:0]  rsp_include_count;
   logic [COUNT_W-1:0]  rsp_exclude_count;

   mac_filter_scoreboard sb;
   int burst_left;
   bit idle_enabled;
   int cycle_count;

   masked_mac_include_exclude_filter #(
      .TABLE_DEPTH(DEPTH)
   ) u_top (
      .clock(clock),
      .reset(reset),
      .start(start),
      .busy(busy),
      .req_func(req_func),
      .req_which_list(req_which_list),
      .req_mac_addr(req_mac_addr),
      .req_addr_mask(req_addr_mask),
      .csr_we(csr_we),
      .csr_wdata(csr_wdata),
      .rsp_valid(rsp_valid),
      .rsp_status(rsp_status),
      .rsp_allowed(rsp_allowed),
      .rsp_include_count(rsp_include_count),
      .rsp_exclude_count(rsp_exclude_count)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   initial begin
      cycle_count = 0;
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("ERROR cycle limit reached with %0d results outstanding", sb.pending());
      $display("** masked_mac_include_exclude_filter: FAILED **");
      $finish;
   end

   always @(posedge clock) begin
      filter_verdict_type got;
      if (!reset && rsp_valid) begin
         got.status = rsp_status;
         got.allowed = rsp_allowed;
         got.incl_count = rsp_include_count;
         got.excl_count = rsp_exclude_count;
         sb.check_verdict(got);
      end
   end

   function automatic logic [MAC_W-1:0] rand_mac();
      logic [63:0] r;
      r = {$urandom, $urandom};
      return r[MAC_W-1:0];
   endfunction

   function automatic logic [MAC_W-1:0] rand_mask();
      case ($urandom_range(0, 5))
         0: return MAC_ONES;
         1: return '0;
         2: return rand_mac();
         3: return MAC_ONES << $urandom_range(0, MAC_W - 1);
         4: return rand_mac() & rand_mac();
         default: return MAC_ONES ^ (48'd1 << $urandom_range(0, MAC_W - 1));
      endcase
   endfunction

   // Mostly addresses near a held entry, so both hits and near misses occur.
   function automatic logic [MAC_W-1:0] query_addr();
      int lst;
      int idx;
      logic [MAC_W-1:0] base;
      logic [MAC_W-1:0] m;
      lst = $urandom_range(0, 1);
      if (sb.used[lst] == 0) lst = 1 - lst;
      if (sb.used[lst] == 0 || $urandom_range(0, 3) == 0)
         return rand_mac();
      idx = $urandom_range(0, sb.used[lst] - 1);
      base = sb.entry_addr[lst][idx];
      m = sb.entry_mask[lst][idx];
      case ($urandom_range(0, 2))
         0: return base ^ (rand_mac() & ~m);
         1: return base ^ (48'd1 << $urandom_range(0, MAC_W - 1));
         default: return base;
      endcase
   endfunction

   task automatic idle_for(int n);
      repeat (n) begin
         @(negedge clock);
         start = 1'b0;
         req_func = FUNC_W'($urandom);
         req_which_list = 1'($urandom);
         req_mac_addr = rand_mac();
         req_addr_mask = rand_mac();
      end
   endtask

   task automatic send_item(logic [FUNC_W-1:0] f, logic w, logic [MAC_W-1:0] a,
                            logic [MAC_W-1:0] m);
      @(negedge clock);
      start = 1'b1;
      req_func = f;
      req_which_list = w;
      req_mac_addr = a;
      req_addr_mask = m;
      @(posedge clock);
      while (busy) @(posedge clock);
      sb.apply_command(f, w, a, m);
      if (idle_enabled) begin
         burst_left--;
         if (burst_left <= 0) begin
            burst_left = $urandom_range(1, 12);
            idle_for($urandom_range(1, 40));
         end
      end
   endtask

   task automatic write_excl_first(bit v);
      @(negedge clock);
      start = 1'b0;
      while (sb.pending() != 0 || busy) @(posedge clock);
      @(negedge clock);
      csr_we = 1'b1;
      csr_wdata = v;
      @(posedge clock);
      sb.excl_first = v;
      sb.config_writes++;
      @(negedge clock);
      csr_we = 1'b0;
      csr_wdata = 1'($urandom);
   endtask

   task automatic directed_items();
      logic [MAC_W-1:0] addr_a;
      logic [MAC_W-1:0] addr_b;
      logic [MAC_W-1:0] addr_c;
      logic [MAC_W-1:0] addr_e;
      addr_a = 48'h0200_0000_0001;
      addr_b = 48'h0200_0000_0000;
      addr_c = 48'h1234_5678_9ABC;
      addr_e = 48'h0A00_0000_0001;
      // Both lists empty: every address passes.
      send_item(FUNC_QUERY, LIST_INCLUDE, '0, '0);
      send_item(FUNC_QUERY, LIST_EXCLUDE, MAC_ONES, MAC_ONES);
      send_item(FUNC_UNUSED, LIST_EXCLUDE, MAC_ONES, MAC_ONES);
      send_item(FUNC_INSERT, LIST_INCLUDE, addr_a, MAC_ONES);
      send_item(FUNC_INSERT, LIST_INCLUDE, addr_a, '0);
      send_item(FUNC_QUERY, LIST_INCLUDE, addr_a, '0);
      send_item(FUNC_QUERY, LIST_INCLUDE, addr_c, '0);
      send_item(FUNC_CLEAR, LIST_EXCLUDE, MAC_ONES, MAC_ONES);
      // A zero mask in the exclude list rejects everything.
      send_item(FUNC_INSERT, LIST_EXCLUDE, '0, '0);
      send_item(FUNC_QUERY, LIST_INCLUDE, MAC_ONES, MAC_ONES);
      send_item(FUNC_CLEAR, LIST_INCLUDE, '0, '0);
      send_item(FUNC_INSERT, LIST_INCLUDE, addr_a, MAC_ONES);
      send_item(FUNC_INSERT, LIST_INCLUDE, addr_e, MAC_ONES);
      send_item(FUNC_INSERT, LIST_EXCLUDE, addr_b, 48'hFFFF_FFFF_0000);
      send_item(FUNC_QUERY, LIST_INCLUDE, addr_a, '0);
      send_item(FUNC_QUERY, LIST_INCLUDE, addr_b, '0);
      send_item(FUNC_QUERY, LIST_INCLUDE, addr_c, '0);
      send_item(FUNC_QUERY, LIST_INCLUDE, addr_e, '0);
      write_excl_first(1'b1);
      send_item(FUNC_QUERY, LIST_EXCLUDE, addr_a, MAC_ONES);
      send_item(FUNC_QUERY, LIST_EXCLUDE, addr_b, MAC_ONES);
      send_item(FUNC_QUERY, LIST_EXCLUDE, addr_c, MAC_ONES);
      send_item(FUNC_QUERY, LIST_EXCLUDE, addr_e, MAC_ONES);
   endtask

   task automatic random_phase(int n_items, int insert_pct, int clear_pct);
      int r;
      logic w;
      logic [MAC_W-1:0] a;
      for (int k = 0; k < n_items; k++) begin
         r = $urandom_range(0, 99);
         w = 1'($urandom);
         if (r < insert_pct) begin
            if (sb.used[w] > 0 && $urandom_range(0, 4) == 0)
               a = sb.entry_addr[w][$urandom_range(0, sb.used[w] - 1)];
            else
               a = rand_mac();
            send_item(FUNC_INSERT, w, a, rand_mask());
         end else if (r < insert_pct + clear_pct) begin
            send_item(FUNC_CLEAR, w, rand_mac(), rand_mac());
         end else if (r < insert_pct + clear_pct + 2) begin
            send_item(FUNC_UNUSED, w, rand_mac(), rand_mac());
         end else begin
            send_item(FUNC_QUERY, w, query_addr(), rand_mac());
         end
      end
   endtask

   initial begin
      sb = new();
      reset = 1'b1;
      start = 1'b0;
      req_func = FUNC_INSERT;
      req_which_list = LIST_INCLUDE;
      req_mac_addr = '0;
      req_addr_mask = '0;
      csr_we = 1'b0;
      csr_wdata = 1'b0;
      idle_enabled = 1'b1;
      burst_left = 4;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      write_excl_first(1'b0);
      directed_items();

      // Phases alternate the register and vary how fast the lists fill.
      for (int p = 0; p < PHASES; p++) begin
         write_excl_first(p[0]);
         idle_enabled = (p != 2);
         random_phase(RANDOM_ITEMS / PHASES, (p == 1 || p == 4) ? 70 : 35,
                      (p % 3 == 0) ? 6 : 1);
      end

      @(negedge clock);
      start = 1'b0;
      while (sb.pending() != 0) @(posedge clock);
      repeat (DEPTH + 4) @(posedge clock);
      sb.flush_leftovers();

      $display("Covered %0d result beats: %0d queries (%0d allowed), %0d inserts",
               sb.verdict_count, sb.query_count, sb.allowed_count, sb.insert_count);
      $display("with %0d duplicates and %0d full-list refusals, %0d clears, %0d register writes",
               sb.present_count, sb.full_count, sb.clear_count, sb.config_writes);
      if (sb.error_count == 0)
         $display("** masked_mac_include_exclude_filter: PASSED **");
      else
         $display("** masked_mac_include_exclude_filter: FAILED **");
      $finish;
   end

endmodule
